/* rtl/fpff_pkg.sv */
// Shared types, constants and partition table of the first-fit scheduler.
`timescale 1ns / 1ps
package fpff_pkg;

    localparam int MAX_JOBS_DEF  = 64;
    localparam int NUM_SLOTS_DEF = 10;

    localparam int ID_W   = 16;
    localparam int SIZE_W = 16;
    localparam int RT_W   = 16;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;
    localparam int PCNT_W = 4;
    localparam int WCNT_W = 7;

    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic [RT_W-1:0]   rt;
    } job_t;

    typedef struct packed {
        logic              accepted;
        logic              done_res;
        logic [ID_W-1:0]   done_job;
        logic [SLOT_W-1:0] done_slot;
        logic [TIME_W-1:0] done_arrival;
        logic [TIME_W-1:0] done_start;
        logic [TIME_W-1:0] done_end;
        logic [PCNT_W-1:0] placed_count;
        logic [WCNT_W-1:0] waiting_count;
        logic [TIME_W-1:0] frag_total;
        logic              idle;
        logic [TIME_W-1:0] now;
    } res_t;

    function automatic logic [SIZE_W-1:0] part_size(input int unsigned j);
        logic [SIZE_W-1:0] s;
        case (j)
            0:       s = SIZE_W'(9500);
            1:       s = SIZE_W'(7000);
            2:       s = SIZE_W'(4500);
            3:       s = SIZE_W'(8500);
            4:       s = SIZE_W'(3000);
            5:       s = SIZE_W'(9000);
            6:       s = SIZE_W'(1000);
            7:       s = SIZE_W'(5500);
            8:       s = SIZE_W'(1500);
            9:       s = SIZE_W'(500);
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/fpff_if.sv */
// Handshake channels for job items and result items.
`timescale 1ns / 1ps
interface fpff_job_if;
    import fpff_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ID_W-1:0]   job_id;
    logic [SIZE_W-1:0] job_size;
    logic [RT_W-1:0]   run_time;

    modport source(output valid, mode, job_id, job_size, run_time, input ready);
    modport sink(input valid, mode, job_id, job_size, run_time, output ready);
endinterface

interface fpff_res_if;
    import fpff_pkg::*;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              done_res;
    logic [ID_W-1:0]   done_job;
    logic [SLOT_W-1:0] done_slot;
    logic [TIME_W-1:0] done_arrival;
    logic [TIME_W-1:0] done_start;
    logic [TIME_W-1:0] done_end;
    logic [PCNT_W-1:0] placed_count;
    logic [WCNT_W-1:0] waiting_count;
    logic [TIME_W-1:0] frag_total;
    logic              idle;
    logic [TIME_W-1:0] now;

    modport source(output valid, accepted, done_res, done_job, done_slot, done_arrival,
                   done_start, done_end, placed_count, waiting_count, frag_total, idle,
                   now, input ready);
    modport sink(input valid, accepted, done_res, done_job, done_slot, done_arrival,
                 done_start, done_end, placed_count, waiting_count, frag_total, idle,
                 now, output ready);
endinterface

/* rtl/fpff_job_mem.sv */
// Job table memory: one write port, one registered read port, plus placed marks.
`timescale 1ns / 1ps
module fpff_job_mem
    import fpff_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF,
    localparam int JIW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic           clk,
    input  logic           we,
    input  logic [JIW-1:0] wa,
    input  job_t           wd,
    input  logic           pwe,
    input  logic [JIW-1:0] pwa,
    input  logic           pwd,
    input  logic           re,
    input  logic [JIW-1:0] ra,
    output job_t           rd,
    output logic           rp
);

    job_t mem [MAX_JOBS];
    logic pmem [MAX_JOBS];
    job_t rd_reg;
    logic rp_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (pwe)
        begin
            pmem[pwa] <= pwd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
            rp_reg <= pmem[ra];
        end
    end

    assign rd = rd_reg;
    assign rp = rp_reg;

endmodule

/* rtl/fixed_partition_first_fit_scheduler.sv */
// Top level of the fixed-partition first-fit job scheduler.
// Usage:
//   job_in carries one item: mode 0 submits a job (id, size, run time) into the
//   job table, mode 1 advances time by one tick. res_out returns exactly one
//   result item per input item.
//   A submit's result is registered on the accepting edge.
//   A tick walks the job table one entry per cycle through the table's single
//   read port, tests every free partition in parallel for each unplaced job,
//   then performs the clock and run/complete step.
//   job_in.ready is high only between items, while the result register is
//   empty or being drained; a new item may be taken in the cycle its
//   predecessor's result is taken.
//   When res_out stalls, the result holds and no further item is accepted.
//   Reset clears the job count, busy partitions, ready queue, time and slack
//   total; each submit writes its own placed mark, so no clearing pass is needed.
`timescale 1ns / 1ps
module fixed_partition_first_fit_scheduler
    import fpff_pkg::*;
#(
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fpff_job_if.sink    job_in,
    fpff_res_if.source  res_out
);

    localparam int JIW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int JCW = $clog2(MAX_JOBS + 1);
    localparam int QIW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QCW = $clog2(NUM_SLOTS + 1);

    state_t            state_reg, state_next;
    logic [JCW-1:0]    job_cnt_reg, job_cnt_next;
    logic [JCW-1:0]    wait_cnt_reg, wait_cnt_next;
    logic [JCW-1:0]    idx_reg, idx_next;
    logic              ev_vld_reg, ev_vld_next;
    logic [JIW-1:0]    ev_idx_reg, ev_idx_next;
    logic [PCNT_W-1:0] plc_cnt_reg, plc_cnt_next;
    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [ID_W-1:0]   q_id_reg [NUM_SLOTS];
    logic [ID_W-1:0]   q_id_next [NUM_SLOTS];
    logic [SLOT_W-1:0] q_slot_reg [NUM_SLOTS];
    logic [SLOT_W-1:0] q_slot_next [NUM_SLOTS];
    logic [TIME_W-1:0] q_arr_reg [NUM_SLOTS];
    logic [TIME_W-1:0] q_arr_next [NUM_SLOTS];
    logic [RT_W-1:0]   q_rt_reg [NUM_SLOTS];
    logic [RT_W-1:0]   q_rt_next [NUM_SLOTS];
    logic [QIW-1:0]    q_head_reg, q_head_next;
    logic [QCW-1:0]    q_cnt_reg, q_cnt_next;
    logic              running_reg, running_next;
    logic [TIME_W-1:0] run_start_reg, run_start_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] slack_reg, slack_next;
    logic              out_vld_reg, out_vld_next;
    res_t              out_reg, out_next;

    logic              mem_we, mem_re;
    logic [JIW-1:0]    mem_wa, mem_ra;
    job_t              mem_wd, mem_rd;
    logic              mem_pwe;
    logic [JIW-1:0]    mem_pwa;
    logic              mem_pwd;
    logic              mem_rp;

    logic              fit_any;
    logic [SLOT_W-1:0] fit_j;
    logic [SIZE_W-1:0] slack;
    logic [TIME_W:0]   slack_sum;
    logic [QCW:0]      tail_raw;
    logic [QIW-1:0]    tail;
    logic              in_fire;
    logic [TIME_W-1:0] now_inc;
    logic              run_v;
    logic [TIME_W-1:0] start_v;
    logic [QCW-1:0]    cnt_v;
    logic              done_v;

    fpff_job_mem #(.MAX_JOBS(MAX_JOBS)) u_mem (
        .clk (clk),
        .we  (mem_we),
        .wa  (mem_wa),
        .wd  (mem_wd),
        .pwe (mem_pwe),
        .pwa (mem_pwa),
        .pwd (mem_pwd),
        .re  (mem_re),
        .ra  (mem_ra),
        .rd  (mem_rd),
        .rp  (mem_rp)
    );

    assign job_in.ready = (state_reg == ST_IDLE) && (!out_vld_reg || res_out.ready);
    assign in_fire      = job_in.valid && job_in.ready;

    // first free partition that holds the job under evaluation
    always_comb
    begin
        fit_any = 1'b0;
        fit_j   = '0;
        for (int j = NUM_SLOTS - 1; j >= 0; j--)
        begin
            if (!busy_reg[j] && (mem_rd.size <= part_size(j)))
            begin
                fit_any = 1'b1;
                fit_j   = SLOT_W'(j);
            end
        end
        slack     = part_size(int'(fit_j)) - mem_rd.size;
        slack_sum = {1'b0, slack_reg} + (TIME_W + 1)'(slack);
        tail_raw  = (QCW + 1)'(q_head_reg) + (QCW + 1)'(q_cnt_reg);
        if (tail_raw >= (QCW + 1)'(NUM_SLOTS))
        begin
            tail_raw = tail_raw - (QCW + 1)'(NUM_SLOTS);
        end
        tail = tail_raw[QIW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        job_cnt_next   = job_cnt_reg;
        wait_cnt_next  = wait_cnt_reg;
        idx_next       = idx_reg;
        ev_vld_next    = ev_vld_reg;
        ev_idx_next    = ev_idx_reg;
        plc_cnt_next   = plc_cnt_reg;
        busy_next      = busy_reg;
        q_id_next      = q_id_reg;
        q_slot_next    = q_slot_reg;
        q_arr_next     = q_arr_reg;
        q_rt_next      = q_rt_reg;
        q_head_next    = q_head_reg;
        q_cnt_next     = q_cnt_reg;
        running_next   = running_reg;
        run_start_next = run_start_reg;
        now_next       = now_reg;
        slack_next     = slack_reg;
        out_vld_next   = out_vld_reg && !res_out.ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_wa         = job_cnt_reg[JIW-1:0];
        mem_wd         = '{id: job_in.job_id, size: job_in.job_size, rt: job_in.run_time};
        mem_pwe        = 1'b0;
        mem_pwa        = job_cnt_reg[JIW-1:0];
        mem_pwd        = 1'b0;
        mem_re         = 1'b0;
        mem_ra         = idx_reg[JIW-1:0];
        now_inc        = now_reg + TIME_W'(1);
        run_v          = running_reg;
        start_v        = run_start_reg;
        cnt_v          = q_cnt_reg;
        done_v         = 1'b0;

        // place the job read in the previous cycle, if it is unplaced and a free partition fits it
        if (ev_vld_reg && !mem_rp && fit_any)
        begin
            mem_pwe                 = 1'b1;
            mem_pwa                 = ev_idx_reg;
            mem_pwd                 = 1'b1;
            busy_next[fit_j]        = 1'b1;
            q_id_next[tail]         = mem_rd.id;
            q_slot_next[tail]       = fit_j;
            q_arr_next[tail]        = now_reg;
            q_rt_next[tail]         = mem_rd.rt;
            q_cnt_next              = q_cnt_reg + QCW'(1);
            slack_next              = slack_sum[TIME_W] ? '1 : slack_sum[TIME_W-1:0];
            plc_cnt_next            = plc_cnt_reg + PCNT_W'(1);
            wait_cnt_next           = wait_cnt_reg - JCW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (job_in.mode == MODE_SUBMIT)
                    begin
                        out_next          = '0;
                        out_next.accepted = job_cnt_reg < JCW'(MAX_JOBS);
                        if (out_next.accepted)
                        begin
                            mem_we        = 1'b1;
                            mem_pwe       = 1'b1;
                            mem_pwa       = job_cnt_reg[JIW-1:0];
                            mem_pwd       = 1'b0;
                            job_cnt_next  = job_cnt_reg + JCW'(1);
                            wait_cnt_next = wait_cnt_reg + JCW'(1);
                        end
                        out_next.waiting_count = WCNT_W'(wait_cnt_next);
                        out_next.frag_total    = slack_reg;
                        out_next.idle          = !running_reg && (q_cnt_reg == '0);
                        out_next.now           = now_reg;
                        out_vld_next           = 1'b1;
                    end
                    else
                    begin
                        idx_next     = '0;
                        ev_vld_next  = 1'b0;
                        plc_cnt_next = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < job_cnt_reg)
                begin
                    mem_re      = 1'b1;
                    ev_vld_next = 1'b1;
                    ev_idx_next = idx_reg[JIW-1:0];
                    idx_next    = idx_reg + JCW'(1);
                end
                else
                begin
                    ev_vld_next = 1'b0;
                    if (!ev_vld_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_vld_reg || res_out.ready)
                begin
                    out_next = '0;
                    if (!run_v && (q_cnt_reg != '0))
                    begin
                        run_v   = 1'b1;
                        start_v = now_inc;
                    end
                    if (run_v && ((now_inc - start_v) == TIME_W'(q_rt_reg[q_head_reg])))
                    begin
                        done_v                = 1'b1;
                        out_next.done_job     = q_id_reg[q_head_reg];
                        out_next.done_slot    = q_slot_reg[q_head_reg];
                        out_next.done_arrival = q_arr_reg[q_head_reg];
                        out_next.done_start   = start_v;
                        out_next.done_end     = now_inc;
                        for (int j = 0; j < NUM_SLOTS; j++)
                        begin
                            if (q_slot_reg[q_head_reg] == SLOT_W'(j))
                            begin
                                busy_next[j] = 1'b0;
                            end
                        end
                        q_head_next = (q_head_reg == QIW'(NUM_SLOTS - 1)) ? '0
                                                                          : q_head_reg + QIW'(1);
                        cnt_v = q_cnt_reg - QCW'(1);
                        if (cnt_v != '0)
                        begin
                            start_v = now_inc;
                        end
                        else
                        begin
                            run_v = 1'b0;
                        end
                    end
                    q_cnt_next             = cnt_v;
                    running_next           = run_v;
                    run_start_next         = start_v;
                    now_next               = now_inc;
                    out_next.done_res      = done_v;
                    out_next.placed_count  = plc_cnt_reg;
                    out_next.waiting_count = WCNT_W'(wait_cnt_reg);
                    out_next.frag_total    = slack_reg;
                    out_next.idle          = !run_v && (cnt_v == '0);
                    out_next.now           = now_inc;
                    out_vld_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_cnt_reg   <= '0;
            wait_cnt_reg  <= '0;
            idx_reg       <= '0;
            ev_vld_reg    <= 1'b0;
            plc_cnt_reg   <= '0;
            busy_reg      <= '0;
            q_head_reg    <= '0;
            q_cnt_reg     <= '0;
            running_reg   <= 1'b0;
            run_start_reg <= '0;
            now_reg       <= '0;
            slack_reg     <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_cnt_reg   <= job_cnt_next;
            wait_cnt_reg  <= wait_cnt_next;
            idx_reg       <= idx_next;
            ev_vld_reg    <= ev_vld_next;
            plc_cnt_reg   <= plc_cnt_next;
            busy_reg      <= busy_next;
            q_head_reg    <= q_head_next;
            q_cnt_reg     <= q_cnt_next;
            running_reg   <= running_next;
            run_start_reg <= run_start_next;
            now_reg       <= now_next;
            slack_reg     <= slack_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg <= ev_idx_next;
        q_id_reg   <= q_id_next;
        q_slot_reg <= q_slot_next;
        q_arr_reg  <= q_arr_next;
        q_rt_reg   <= q_rt_next;
        out_reg    <= out_next;
    end

    assign res_out.valid         = out_vld_reg;
    assign res_out.accepted      = out_reg.accepted;
    assign res_out.done_res      = out_reg.done_res;
    assign res_out.done_job      = out_reg.done_job;
    assign res_out.done_slot     = out_reg.done_slot;
    assign res_out.done_arrival  = out_reg.done_arrival;
    assign res_out.done_start    = out_reg.done_start;
    assign res_out.done_end      = out_reg.done_end;
    assign res_out.placed_count  = out_reg.placed_count;
    assign res_out.waiting_count = out_reg.waiting_count;
    assign res_out.frag_total    = out_reg.frag_total;
    assign res_out.idle          = out_reg.idle;
    assign res_out.now           = out_reg.now;

`ifndef SYNTHESIS
    a_busy_matches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_reg) == int'(q_cnt_reg))
        else $error("busy partitions differ from ready queue depth");

    a_wait_le_jobs: assert property (@(posedge clk) disable iff (!rst_n)
        wait_cnt_reg <= job_cnt_reg)
        else $error("waiting count exceeds job count");

    a_run_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (q_cnt_reg != '0))
        else $error("running with empty ready queue");

    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && (!out_vld_reg || res_out.ready)) |=>
            (out_vld_reg && state_reg == ST_IDLE && !out_reg.accepted))
        else $error("tick did not produce a result");
`endif

endmodule
